[rtl/core/ldpc_cnu_pkg.sv]
package ldpc_cnu_pkg;

  // Geometry of one check node
  localparam int MAX_DEGREE  = 16;
  localparam int INDEX_WIDTH = 10;
  localparam int LLR_W       = 8;
  localparam int MAG_W       = LLR_W - 1;
  localparam int ADDR_W      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int CNT_W       = $clog2(MAX_DEGREE + 1);
  localparam int LLR_LIMIT   = 127;

  typedef logic signed [LLR_W-1:0] llr_t;
  typedef logic [MAG_W-1:0]        mag_t;
  typedef logic [INDEX_WIDTH-1:0]  index_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [CNT_W-1:0]        count_t;

  // Edge store control from the sequencer
  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    logic  rd_en;
    addr_t rd_addr;
  } store_ctl_t;

  // Magnitude of a value already limited to [-LLR_LIMIT, LLR_LIMIT]
  function automatic mag_t mag_of(input llr_t v);
    llr_t n;
    n = -v;
    return v[LLR_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

endpackage

[rtl/core/ldpc_cnu_satadd.sv]
module ldpc_cnu_satadd (
  input  ldpc_cnu_pkg::llr_t a,
  input  ldpc_cnu_pkg::llr_t b,
  input  logic               sub,
  output ldpc_cnu_pkg::llr_t y
);
  import ldpc_cnu_pkg::*;

  localparam int SUM_W = LLR_W + 2;

  logic signed [SUM_W-1:0] a_ext;
  logic signed [SUM_W-1:0] b_ext;
  logic signed [SUM_W-1:0] sum;

  // Widen both operands, add or subtract
  assign a_ext = SUM_W'(a);
  assign b_ext = SUM_W'(b);
  assign sum   = sub ? (a_ext - b_ext) : (a_ext + b_ext);

  // Clamp to the symmetric LLR range
  always_comb begin
    if (sum > SUM_W'(LLR_LIMIT)) begin
      y = llr_t'(LLR_LIMIT);
    end else if (sum < -SUM_W'(LLR_LIMIT)) begin
      y = -llr_t'(LLR_LIMIT);
    end else begin
      y = sum[LLR_W-1:0];
    end
  end

endmodule

[rtl/core/ldpc_cnu_store.sv]
module ldpc_cnu_store (
  input  logic                      clk,
  input  ldpc_cnu_pkg::store_ctl_t  ctl,
  input  ldpc_cnu_pkg::llr_t        wr_ext,
  input  ldpc_cnu_pkg::index_t      wr_index,
  output ldpc_cnu_pkg::llr_t        rd_ext,
  output ldpc_cnu_pkg::index_t      rd_index
);
  import ldpc_cnu_pkg::*;

  llr_t   ext_mem [MAX_DEGREE];
  index_t idx_mem [MAX_DEGREE];

  // Write one edge
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      ext_mem[ctl.wr_addr] <= wr_ext;
      idx_mem[ctl.wr_addr] <= wr_index;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_ext   <= ext_mem[ctl.rd_addr];
      rd_index <= idx_mem[ctl.rd_addr];
    end
  end

endmodule

[rtl/core/ldpc_min_sum_check_node_unit.sv]
// Each edge beat is captured, then its extrinsic is folded through the shared adder.
// After the beat marked last is folded, results follow one at a time: a store read,
// then message and sum through the same adder, then a load of the output register,
// which waits while the output stalls. Input is stalled from the last edge until the
// final result sits in the output register. rst (synchronous, active high) clears the
// sequencer, minima, parity, edge count and output valid; the edge store is not cleared.
module ldpc_min_sum_check_node_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ldpc_cnu_pkg::index_t  vn_index,
  input  ldpc_cnu_pkg::llr_t    posterior,
  input  ldpc_cnu_pkg::llr_t    old_message,
  input  logic                  last_edge,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ldpc_cnu_pkg::index_t  out_index,
  output ldpc_cnu_pkg::llr_t    new_message,
  output ldpc_cnu_pkg::llr_t    new_posterior,
  output logic                  last
);
  import ldpc_cnu_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FOLD = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_CALC = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  index_t index_q;
  llr_t   post_q;
  llr_t   old_q;
  logic   last_q;

  mag_t   min_first;
  mag_t   min_second;
  logic   sign_parity;
  count_t edge_count;
  addr_t  emit_ptr;

  store_ctl_t store_ctl;
  llr_t       rd_ext;
  index_t     rd_index;

  llr_t add_a;
  llr_t add_b;
  logic add_sub;
  llr_t add_y;

  mag_t   ext_mag;
  mag_t   hi_mag;
  logic   has_room;
  mag_t   rd_mag;
  mag_t   msg_mag;
  llr_t   msg_pos;
  llr_t   msg;
  logic   out_free;
  logic   emit_last;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Fold-side terms
  assign ext_mag  = mag_of(add_y);
  assign hi_mag   = (ext_mag > min_first) ? ext_mag : min_first;
  assign has_room = (edge_count < CNT_W'(MAX_DEGREE));

  // Emit-side message
  assign rd_mag    = mag_of(rd_ext);
  assign msg_mag   = (rd_mag == min_first) ? min_second : min_first;
  assign msg_pos   = llr_t'({1'b0, msg_mag});
  assign msg       = (sign_parity ^ rd_ext[LLR_W-1]) ? -msg_pos : msg_pos;
  assign emit_last = ((CNT_W'(emit_ptr) + CNT_W'(1)) == edge_count);

  // Share the adder between fold and emit
  always_comb begin
    if (state == S_FOLD) begin
      add_a   = post_q;
      add_b   = old_q;
      add_sub = 1'b1;
    end else begin
      add_a   = rd_ext;
      add_b   = msg;
      add_sub = 1'b0;
    end
  end

  ldpc_cnu_satadd u_satadd (
    .a   (add_a),
    .b   (add_b),
    .sub (add_sub),
    .y   (add_y)
  );

  // Store control
  always_comb begin
    store_ctl.wr_en   = (state == S_FOLD) && has_room;
    store_ctl.wr_addr = edge_count[ADDR_W-1:0];
    store_ctl.rd_en   = (state == S_READ);
    store_ctl.rd_addr = emit_ptr;
  end

  ldpc_cnu_store u_store (
    .clk      (clk),
    .ctl      (store_ctl),
    .wr_ext   (add_y),
    .wr_index (index_q),
    .rd_ext   (rd_ext),
    .rd_index (rd_index)
  );

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_FOLD;
      S_FOLD: state_next = last_q ? S_READ : S_IDLE;
      S_READ: state_next = S_CALC;
      S_CALC: begin
        if (out_free) state_next = emit_last ? S_IDLE : S_READ;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Capture the accepted beat
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      index_q <= vn_index;
      post_q  <= posterior;
      old_q   <= old_message;
      last_q  <= last_edge;
    end
  end

  // Control, minima and parity
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      min_first   <= mag_t'(LLR_LIMIT);
      min_second  <= mag_t'(LLR_LIMIT);
      sign_parity <= 1'b0;
      edge_count  <= '0;
      emit_ptr    <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_FOLD: begin
          // fold one edge; drop it once the store is full
          if (has_room) begin
            sign_parity <= sign_parity ^ add_y[LLR_W-1];
            min_second  <= (hi_mag < min_second) ? hi_mag : min_second;
            if (ext_mag < min_first) min_first <= ext_mag;
            edge_count  <= edge_count + CNT_W'(1);
          end
          emit_ptr <= '0;
        end
        S_CALC: begin
          if (out_free) begin
            if (emit_last) begin
              min_first   <= mag_t'(LLR_LIMIT);
              min_second  <= mag_t'(LLR_LIMIT);
              sign_parity <= 1'b0;
              edge_count  <= '0;
              emit_ptr    <= '0;
            end else begin
              emit_ptr <= emit_ptr + addr_t'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: load when free, drop valid when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_CALC && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CALC && out_free) begin
      out_index     <= rd_index;
      new_message   <= msg;
      new_posterior <= add_y;
      last          <= emit_last;
    end
  end

endmodule

[rtl/core/ldpc_cnu_checker.sv]
module ldpc_cnu_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  last_edge,
  input logic                  out_valid,
  input logic                  out_stall,
  input ldpc_cnu_pkg::index_t  out_index,
  input ldpc_cnu_pkg::llr_t    new_message,
  input ldpc_cnu_pkg::llr_t    new_posterior,
  input logic                  last
);

  // Every beat passes through the fold state before the next one is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken back to back");

  // Closing beat keeps intake shut through the first read
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_edge |=> in_stall ##1 in_stall ##1 in_stall)
    else $error("intake reopened during emit start");

  // No intake while a non-final result is pending
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("input open mid check node");

  // Stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_index) && $stable(new_message)
      && $stable(new_posterior) && $stable(last))
    else $error("stalled result changed");

endmodule

bind ldpc_min_sum_check_node_unit ldpc_cnu_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .last_edge     (last_edge),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_index     (out_index),
  .new_message   (new_message),
  .new_posterior (new_posterior),
  .last          (last)
);
